@@ design/bwm_pkg.sv @@
// Shared types, constants and helpers for the barcode whitelist matcher.
package bwm_pkg;

	localparam int WL_DEPTH_DEF     = 4096;
	localparam int MAX_CB_BASES_DEF = 16;

	localparam logic [3:0] ST_EXACT    = 4'd0;
	localparam logic [3:0] ST_NFIX     = 4'd1;
	localparam logic [3:0] ST_MM       = 4'd2;
	localparam logic [3:0] ST_DISABLED = 4'd3;
	localparam logic [3:0] ST_NREJ     = 4'd4;
	localparam logic [3:0] ST_HOMO     = 4'd5;
	localparam logic [3:0] ST_AMBIG    = 4'd6;
	localparam logic [3:0] ST_NOMATCH  = 4'd7;
	localparam logic [3:0] ST_LOADED   = 4'd8;
	localparam logic [3:0] ST_READOUT  = 4'd9;

	localparam logic [1:0] RQ_LOAD  = 2'd0;
	localparam logic [1:0] RQ_MATCH = 2'd1;
	localparam logic [1:0] RQ_CNT   = 2'd2;
	localparam logic [1:0] RQ_STAT  = 2'd3;

	localparam logic [1:0] SC_NBASE = 2'd0;
	localparam logic [1:0] SC_HOMO  = 2'd1;
	localparam logic [1:0] SC_AMBIG = 2'd2;
	localparam logic [1:0] SC_NOHIT = 2'd3;

	localparam logic [2:0] CFG_SOLO = 3'd0;
	localparam logic [2:0] CFG_CBL  = 3'd1;
	localparam logic [2:0] CFG_UMIL = 3'd2;
	localparam logic [2:0] CFG_GENE = 3'd3;
	localparam logic [2:0] CFG_WLSZ = 3'd4;

	// request classes seen at dispatch
	localparam logic [2:0] K_LOAD  = 3'd0;
	localparam logic [2:0] K_CNT   = 3'd1;
	localparam logic [2:0] K_STAT  = 3'd2;
	localparam logic [2:0] K_REJ   = 3'd3;
	localparam logic [2:0] K_NFIX  = 3'd4;
	localparam logic [2:0] K_CLEAN = 3'd5;

	// candidate modes
	localparam logic [1:0] M_NFIX  = 2'd0;
	localparam logic [1:0] M_EXACT = 2'd1;
	localparam logic [1:0] M_MM    = 2'd2;

	// result selection
	localparam logic [3:0] E_LOAD      = 4'd0;
	localparam logic [3:0] E_CNT       = 4'd1;
	localparam logic [3:0] E_STAT      = 4'd2;
	localparam logic [3:0] E_REJ       = 4'd3;
	localparam logic [3:0] E_NFIX      = 4'd4;
	localparam logic [3:0] E_EXACT     = 4'd5;
	localparam logic [3:0] E_PEND      = 4'd6;
	localparam logic [3:0] E_PEND_LAST = 4'd7;
	localparam logic [3:0] E_NOMATCH   = 4'd8;
	localparam logic [3:0] E_AMBIG     = 4'd9;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [11:0] wl_index;
		logic [31:0] wl_value;
		logic [31:0] cb_code;
		logic [15:0] cb_n_mask;
		logic [31:0] umi_code;
		logic [15:0] umi_n_mask;
		logic [1:0]  stat_select;
	} req_t;

	typedef struct packed {
		logic [3:0]  status;
		logic [11:0] match_index;
		logic [3:0]  mismatch_pos;
		logic        last;
		logic [31:0] exact_count;
		logic [31:0] mm_count;
		logic [31:0] stat_value;
	} res_t;

	typedef struct packed {
		logic       capture;
		logic       clr;
		logic       load_wr;
		logic       cnt_rd;
		logic       emit;
		logic [3:0] emit_sel;
		logic       stat_inc;
		logic [1:0] stat_sel;
		logic       init_nfix;
		logic       init_exact;
		logic       init_mm;
		logic       cand_next;
		logic       srch_init;
		logic       probe_rd;
		logic       probe_upd;
		logic       fin_rd;
		logic       found_set;
		logic       pend_set;
		logic       inc_rd;
		logic       inc_wr;
	} cmd_t;

	typedef struct packed {
		logic       clr_done;
		logic [2:0] kind;
		logic       rej_stat_en;
		logic [1:0] rej_stat_sel;
		logic       gene;
		logic [1:0] mode;
		logic       srch_more;
		logic       hit;
		logic       cand_last;
		logic       found_valid;
		logic       pend_valid;
	} sts_t;

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	function automatic logic [4:0] clamp_len(input logic [4:0] v, input logic [4:0] mx);
		logic [4:0] r;
		r = v;
		if (v == 5'd0) r = 5'd1;
		if (v > mx) r = mx;
		return r;
	endfunction

	function automatic logic [31:0] code_mask(input logic [4:0] len);
		logic [31:0] m;
		m = '0;
		for (int i = 0; i < 16; i++) begin
			if (5'(i) < len) m[2*i +: 2] = 2'b11;
		end
		return m;
	endfunction

	function automatic logic [15:0] base_mask(input logic [4:0] len);
		logic [15:0] m;
		m = '0;
		for (int i = 0; i < 16; i++) begin
			if (5'(i) < len) m[i] = 1'b1;
		end
		return m;
	endfunction

endpackage

@@ design/bwm_ctrl.sv @@
// Sequencer for the barcode whitelist matcher.
module bwm_ctrl import bwm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [3:0] S_CLEAR  = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_DISP   = 4'd2;
	localparam logic [3:0] S_CNTOUT = 4'd3;
	localparam logic [3:0] S_SINIT  = 4'd4;
	localparam logic [3:0] S_STEP   = 4'd5;
	localparam logic [3:0] S_CMP    = 4'd6;
	localparam logic [3:0] S_FIN    = 4'd7;
	localparam logic [3:0] S_INCWR  = 4'd8;

	logic [3:0] state_q, state_d;

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				case (sts.kind)
					K_LOAD: begin
						cmd.load_wr = 1'b1;
						cmd.emit = 1'b1;
						cmd.emit_sel = E_LOAD;
						state_d = S_IDLE;
					end
					K_CNT: begin
						cmd.cnt_rd = 1'b1;
						state_d = S_CNTOUT;
					end
					K_STAT: begin
						cmd.emit = 1'b1;
						cmd.emit_sel = E_STAT;
						state_d = S_IDLE;
					end
					K_REJ: begin
						cmd.emit = 1'b1;
						cmd.emit_sel = E_REJ;
						cmd.stat_inc = sts.rej_stat_en;
						cmd.stat_sel = sts.rej_stat_sel;
						state_d = S_IDLE;
					end
					K_NFIX: begin
						cmd.init_nfix = 1'b1;
						state_d = S_SINIT;
					end
					default: begin
						cmd.init_exact = sts.gene;
						cmd.init_mm = !sts.gene;
						state_d = S_SINIT;
					end
				endcase
			end
			S_CNTOUT: begin
				cmd.emit = 1'b1;
				cmd.emit_sel = E_CNT;
				state_d = S_IDLE;
			end
			S_SINIT: begin
				cmd.srch_init = 1'b1;
				state_d = S_STEP;
			end
			S_STEP: begin
				if (sts.srch_more) begin
					cmd.probe_rd = 1'b1;
					state_d = S_CMP;
				end else begin
					cmd.fin_rd = 1'b1;
					state_d = S_FIN;
				end
			end
			S_CMP: begin
				cmd.probe_upd = 1'b1;
				state_d = S_STEP;
			end
			S_FIN: begin
				case (sts.mode)
					M_NFIX: begin
						if (sts.hit && sts.found_valid) begin
							cmd.emit = 1'b1;
							cmd.emit_sel = E_AMBIG;
							cmd.stat_inc = 1'b1;
							cmd.stat_sel = SC_AMBIG;
							state_d = S_IDLE;
						end else if (sts.cand_last) begin
							cmd.emit = 1'b1;
							if (sts.hit || sts.found_valid) begin
								cmd.emit_sel = E_NFIX;
							end else begin
								cmd.emit_sel = E_NOMATCH;
								cmd.stat_inc = 1'b1;
								cmd.stat_sel = SC_NOHIT;
							end
							state_d = S_IDLE;
						end else begin
							cmd.found_set = sts.hit;
							cmd.cand_next = 1'b1;
							state_d = S_SINIT;
						end
					end
					M_EXACT: begin
						if (sts.hit) begin
							cmd.emit = 1'b1;
							cmd.emit_sel = E_EXACT;
							cmd.inc_rd = 1'b1;
							state_d = S_INCWR;
						end else begin
							cmd.init_mm = 1'b1;
							state_d = S_SINIT;
						end
					end
					default: begin
						if (sts.hit) begin
							cmd.emit = sts.pend_valid;
							cmd.emit_sel = E_PEND;
							cmd.pend_set = 1'b1;
							cmd.inc_rd = 1'b1;
							state_d = S_INCWR;
						end else if (sts.cand_last) begin
							cmd.emit = 1'b1;
							if (sts.pend_valid) begin
								cmd.emit_sel = E_PEND_LAST;
							end else begin
								cmd.emit_sel = E_NOMATCH;
								cmd.stat_inc = 1'b1;
								cmd.stat_sel = SC_NOHIT;
							end
							state_d = S_IDLE;
						end else begin
							cmd.cand_next = 1'b1;
							state_d = S_SINIT;
						end
					end
				endcase
			end
			S_INCWR: begin
				cmd.inc_wr = 1'b1;
				if (sts.mode == M_EXACT) begin
					state_d = S_IDLE;
				end else if (sts.cand_last) begin
					cmd.emit = 1'b1;
					cmd.emit_sel = E_PEND_LAST;
					state_d = S_IDLE;
				end else begin
					cmd.cand_next = 1'b1;
					state_d = S_SINIT;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

@@ design/bwm_dp.sv @@
// Datapath: whitelist and count memories, search registers, result register.
module bwm_dp import bwm_pkg::*; #(
	parameter int WL_DEPTH     = WL_DEPTH_DEF,
	parameter int MAX_CB_BASES = MAX_CB_BASES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  req_t        req,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [12:0] cfg_data,
	input  cmd_t        cmd,
	output sts_t        sts,
	output logic        done,
	output res_t        result
);

	localparam int AW = (WL_DEPTH > 1) ? $clog2(WL_DEPTH) : 1;
	localparam int NW = AW + 1;
	localparam logic [4:0] MAXB = 5'(MAX_CB_BASES);

	logic        solo_q, gene_q;
	logic [4:0]  cbl_q, umil_q;
	logic [12:0] wlsz_q;

	req_t        rq_q;
	logic [31:0] wl_mem [WL_DEPTH];
	logic [31:0] ec_mem [WL_DEPTH];
	logic [31:0] mc_mem [WL_DEPTH];
	logic [31:0] wl_rd_q, ec_rd_q, mc_rd_q;
	logic [31:0] stat_q [4];

	logic [NW-1:0] clr_q, lo_q, hi_q, mid_q, n_w, mid_w;
	logic [1:0]    mode_q, b_q;
	logic [3:0]    k_q, np_q;
	logic [31:0]   cand_q, cand_w;
	logic          found_q, pend_q, cnt_ok_q;
	logic [11:0]   found_idx_q, pend_idx_q;
	logic [3:0]    pend_pos_q;
	logic          done_q;
	res_t          res_q, res_w;

	// read decode
	logic [4:0]  cl, ul;
	logic [31:0] um, umi, cb, cb_base;
	logic [15:0] umi_n, cb_n;
	logic        homo;
	logic [4:0]  nn;
	logic [3:0]  posn;
	logic        widx_ok, hit;

	always_comb begin
		cl = clamp_len(cbl_q, MAXB);
		ul = clamp_len(umil_q, MAXB);
		um = code_mask(ul);
		umi = rq_q.umi_code & um;
		umi_n = rq_q.umi_n_mask & base_mask(ul);
		cb = rq_q.cb_code & code_mask(cl);
		cb_n = rq_q.cb_n_mask & base_mask(cl);
		homo = (umi == 32'd0) || (umi == (32'h5555_5555 & um)) ||
			(umi == (32'hAAAA_AAAA & um)) || (umi == um);
		nn = '0;
		posn = '0;
		for (int i = 0; i < 16; i++) begin
			if (cb_n[i]) begin
				nn = nn + 5'd1;
				posn = 4'(i);
			end
		end
		cb_base = cb & ~(32'd3 << {np_q, 1'b0});
	end

	assign widx_ok = ({20'd0, rq_q.wl_index} < 32'(WL_DEPTH));
	assign n_w = ({19'd0, wlsz_q} > 32'(WL_DEPTH)) ? NW'(WL_DEPTH) : NW'(wlsz_q);
	assign mid_w = lo_q + ((hi_q - lo_q) >> 1);
	assign hit = (lo_q < n_w) && (wl_rd_q == cand_q);

	always_comb begin
		case (mode_q)
			M_NFIX:  cand_w = cb_base | ({30'd0, b_q} << {np_q, 1'b0});
			M_EXACT: cand_w = cb;
			default: cand_w = cb ^ ({30'd0, b_q} << {k_q, 1'b0});
		endcase
	end

	always_comb begin
		sts = '0;
		sts.clr_done = (clr_q == NW'(WL_DEPTH - 1));
		sts.gene = gene_q;
		sts.mode = mode_q;
		sts.srch_more = (lo_q < hi_q);
		sts.hit = hit;
		sts.found_valid = found_q;
		sts.pend_valid = pend_q;
		sts.cand_last = (mode_q == M_NFIX) ? (b_q == 2'd3) :
			((b_q == 2'd3) && ({1'b0, k_q} == cl - 5'd1));
		case (rq_q.req_type)
			RQ_LOAD: sts.kind = K_LOAD;
			RQ_CNT:  sts.kind = K_CNT;
			RQ_STAT: sts.kind = K_STAT;
			default: begin
				if (!solo_q || (umi_n != 16'd0) || homo || (nn >= 5'd2)) begin
					sts.kind = K_REJ;
				end else if (nn == 5'd1) begin
					sts.kind = K_NFIX;
				end else begin
					sts.kind = K_CLEAN;
				end
			end
		endcase
		sts.rej_stat_en = solo_q;
		sts.rej_stat_sel = (umi_n == 16'd0 && homo) ? SC_HOMO : SC_NBASE;
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			solo_q <= 1'b1;
			cbl_q <= 5'd16;
			umil_q <= 5'd12;
			gene_q <= 1'b1;
			wlsz_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SOLO: solo_q <= cfg_data[0];
				CFG_CBL:  cbl_q <= cfg_data[4:0];
				CFG_UMIL: umil_q <= cfg_data[4:0];
				CFG_GENE: gene_q <= cfg_data[0];
				CFG_WLSZ: wlsz_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// whitelist memory
	always_ff @(posedge clk) begin
		if (cmd.load_wr && widx_ok) wl_mem[AW'(rq_q.wl_index)] <= rq_q.wl_value;
		if (cmd.probe_rd) begin
			wl_rd_q <= wl_mem[AW'(mid_w)];
		end else if (cmd.fin_rd) begin
			wl_rd_q <= wl_mem[AW'(lo_q)];
		end
	end

	// count memories
	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			ec_mem[AW'(clr_q)] <= '0;
			mc_mem[AW'(clr_q)] <= '0;
		end else if (cmd.inc_wr) begin
			if (mode_q == M_EXACT) begin
				ec_mem[AW'(lo_q)] <= sat_inc(ec_rd_q);
			end else begin
				mc_mem[AW'(lo_q)] <= sat_inc(mc_rd_q);
			end
		end
		if (cmd.cnt_rd) begin
			ec_rd_q <= ec_mem[AW'(rq_q.wl_index)];
			mc_rd_q <= mc_mem[AW'(rq_q.wl_index)];
		end else if (cmd.inc_rd) begin
			ec_rd_q <= ec_mem[AW'(lo_q)];
			mc_rd_q <= mc_mem[AW'(lo_q)];
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			done_q <= 1'b0;
			found_q <= 1'b0;
			pend_q <= 1'b0;
			for (int i = 0; i < 4; i++) stat_q[i] <= '0;
		end else begin
			done_q <= cmd.emit;
			if (cmd.clr) clr_q <= clr_q + NW'(1);
			if (cmd.capture) begin
				found_q <= 1'b0;
				pend_q <= 1'b0;
			end
			if (cmd.found_set) found_q <= 1'b1;
			if (cmd.pend_set) pend_q <= 1'b1;
			if (cmd.stat_inc) stat_q[cmd.stat_sel] <= sat_inc(stat_q[cmd.stat_sel]);
		end
	end

	// result selection
	always_comb begin
		res_w = '0;
		res_w.last = 1'b1;
		case (cmd.emit_sel)
			E_LOAD: begin
				res_w.status = ST_LOADED;
				res_w.match_index = rq_q.wl_index;
			end
			E_CNT: begin
				res_w.status = ST_READOUT;
				res_w.match_index = rq_q.wl_index;
				res_w.exact_count = cnt_ok_q ? ec_rd_q : 32'd0;
				res_w.mm_count = cnt_ok_q ? mc_rd_q : 32'd0;
			end
			E_STAT: begin
				res_w.status = ST_READOUT;
				res_w.stat_value = stat_q[rq_q.stat_select];
			end
			E_REJ: begin
				if (!solo_q) res_w.status = ST_DISABLED;
				else if (umi_n == 16'd0 && homo) res_w.status = ST_HOMO;
				else res_w.status = ST_NREJ;
			end
			E_NFIX: begin
				res_w.status = ST_NFIX;
				res_w.match_index = found_q ? found_idx_q : 12'(lo_q);
			end
			E_EXACT: begin
				res_w.status = ST_EXACT;
				res_w.match_index = 12'(lo_q);
			end
			E_PEND, E_PEND_LAST: begin
				res_w.status = ST_MM;
				res_w.match_index = pend_idx_q;
				res_w.mismatch_pos = pend_pos_q;
				res_w.last = (cmd.emit_sel == E_PEND_LAST);
			end
			E_AMBIG: res_w.status = ST_AMBIG;
			default: res_w.status = ST_NOMATCH;
		endcase
	end

	// search and payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) rq_q <= req;
		if (cmd.cnt_rd) cnt_ok_q <= widx_ok;
		if (cmd.init_nfix) begin
			mode_q <= M_NFIX;
			b_q <= 2'd0;
			np_q <= 4'(cl - 5'd1 - {1'b0, posn});
		end
		if (cmd.init_exact) mode_q <= M_EXACT;
		if (cmd.init_mm) begin
			mode_q <= M_MM;
			k_q <= 4'd0;
			b_q <= 2'd1;
		end
		if (cmd.cand_next) begin
			if (mode_q == M_MM && b_q == 2'd3) begin
				b_q <= 2'd1;
				k_q <= k_q + 4'd1;
			end else begin
				b_q <= b_q + 2'd1;
			end
		end
		if (cmd.srch_init) begin
			cand_q <= cand_w;
			lo_q <= '0;
			hi_q <= n_w;
		end
		if (cmd.probe_rd) mid_q <= mid_w;
		if (cmd.probe_upd) begin
			if (wl_rd_q < cand_q) begin
				lo_q <= mid_q + NW'(1);
			end else begin
				hi_q <= mid_q;
			end
		end
		if (cmd.found_set) found_idx_q <= 12'(lo_q);
		if (cmd.pend_set) begin
			pend_idx_q <= 12'(lo_q);
			pend_pos_q <= k_q;
		end
		if (cmd.emit) res_q <= res_w;
	end

	assign done = done_q;
	assign result = res_q;

endmodule

@@ design/barcode_whitelist_match_1mm_top.sv @@
// Top level of the barcode whitelist matcher with one-mismatch correction.
// Every request is captured and then dispatched by the sequencer; a match request
// runs up to 49 whitelist lookups, each a binary search, and each counted hit adds
// a count memory read and write.
// One request at a time; results are strobed by done for one cycle, never stalled.
// After reset the count memories are cleared while busy is high.
module barcode_whitelist_match_1mm_top import bwm_pkg::*; #(
	parameter int WL_DEPTH     = WL_DEPTH_DEF,
	parameter int MAX_CB_BASES = MAX_CB_BASES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  req_t        req,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [12:0] cfg_data,
	output logic        done,
	output res_t        result
);

	cmd_t cmd;
	sts_t sts;

	bwm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	bwm_dp #(
		.WL_DEPTH     (WL_DEPTH),
		.MAX_CB_BASES (MAX_CB_BASES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.done      (done),
		.result    (result)
	);

endmodule
